// ----- sv/gbs_pkg.sv -----
// Shared constants, types and codes for the grid height bilinear sampler.
package gbs_pkg;

    localparam int MAX_SIDE    = 128;
    localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CLR_W       = ADDR_W + 1;

    localparam int DIV_STEPS   = 16;   // 8 cell bits + 8 fraction bits
    localparam int REM_W       = 41;   // num < 2^33, shifted left by 8
    localparam int LOC_LAT     = DIV_STEPS + 2;

    localparam int CFG_IDX_W   = 8;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 8'd1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Values derived from the config registers, refreshed every cycle.
    typedef struct packed {
        logic [7:0]  side;     // grid_side
        logic [24:0] dvsr;     // 2 * cell_size
        logic [31:0] offset;   // cell_size * (grid_side - 1)
        logic [32:0] limit;    // 2 * offset
        logic        degen;    // grid_side < 2 or cell_size == 0
    } cfg_t;

    // Per-item side info that travels alongside the datapath.
    typedef struct packed {
        logic               op;
        logic               degen;
        logic [ADDR_W-1:0]  cell_index;
        logic [31:0]        height;
    } side_t;

endpackage

// ----- sv/grid_height_bilinear_sampler.sv -----
// Top level of the grid height bilinear sampler.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  s       | s_tvalid s_tready s_tdata[111:0] s_tuser  | request in
//  m       | m_tvalid m_tready m_tdata[31:0]           | result out
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | register write
//
// One request per cycle while m is not stalled and the clearing pass is done.
// Per axis a 16-stage restoring divider (one quotient bit per stage) gives cell
// and fraction; two RAM copies with two read ports give the 4 corners.
// After reset a clearing pass zeroes the height store, with s_tready low until
// it is done. Config writes are always taken (cfg_ready is tied high).
// A stall on m holds every stage; nothing is dropped or repeated.
module grid_height_bilinear_sampler import gbs_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    // requests: tdata = cell_index[13:0], height_value[45:14],
    //           query_x[77:46], query_y[109:78], zero pad [111:110]
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [111:0]         s_tdata,
    input  logic                 s_tuser,   // op: 0 write, 1 query
    // results: tdata = height_out[31:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,
    // config: index 0 grid_side, index 1 cell_size
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [23:0]          cfg_data
);

    localparam int NSTG = 26;
    localparam int S_LOC = LOC_LAT;       // locate outputs valid here
    localparam int S_ADR = S_LOC + 1;     // base address, RAM access
    localparam int S_RD  = S_ADR + 1;     // RAM data
    localparam int S_LO  = S_RD + 2;      // x interpolations done
    localparam int S_Y   = S_LO + 2;      // y interpolation done
    localparam int S_OUT = S_Y + 1;

    // ---- config registers ----
    logic [7:0]  side_reg;
    logic [23:0] cell_reg;
    cfg_t        cfg_reg;
    cfg_t        cfg_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
            cell_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_GRID_SIDE: side_reg <= cfg_data[7:0];
                REG_CELL_SIZE: cell_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg_next.side   = side_reg;
        cfg_next.dvsr   = {cell_reg, 1'b0};
        cfg_next.offset = {8'd0, cell_reg} * {24'd0, side_reg - 8'd1};
        cfg_next.limit  = {cfg_next.offset, 1'b0};
        cfg_next.degen  = (side_reg < 8'd2) || (cell_reg == 24'd0);
    end

    // derived values are registered; items use them from stage 1 on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---- store clearing pass ----
    logic [CLR_W-1:0] clr_reg;
    logic             clr_done;

    assign clr_done = clr_reg[CLR_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (!clr_done)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // ---- pipeline control ----
    logic [NSTG-1:0] v_reg;
    side_t           side_pipe [NSTG];
    logic            adv;

    assign adv      = !v_reg[S_OUT] || m_tready;
    assign s_tready = adv && clr_done;

    logic [31:0] x_reg;
    logic [31:0] y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NSTG-2:0], s_tvalid && s_tready};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s_tvalid && s_tready)
        begin
            side_pipe[0].op         <= s_tuser;
            side_pipe[0].degen      <= 1'b0;
            side_pipe[0].cell_index <= s_tdata[13:0];
            side_pipe[0].height     <= s_tdata[45:14];
            x_reg                   <= s_tdata[77:46];
            y_reg                   <= s_tdata[109:78];
        end
    end

    for (genvar i = 1; i < NSTG; i++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (i == 1)
                begin
                    side_pipe[i] <= '{op: side_pipe[0].op, degen: cfg_reg.degen,
                                      cell_index: side_pipe[0].cell_index,
                                      height: side_pipe[0].height};
                end
                else
                begin
                    side_pipe[i] <= side_pipe[i-1];
                end
            end
        end
    end

    // ---- locate per axis ----
    logic [7:0] col;
    logic [7:0] row;
    logic [8:0] fx;
    logic [8:0] fy;

    gbs_locate u_loc_x (
        .clk      (clk),
        .adv      (adv),
        .cfg      (cfg_reg),
        .coord    (x_reg),
        .cell_idx (col),
        .frac     (fx)
    );

    gbs_locate u_loc_y (
        .clk      (clk),
        .adv      (adv),
        .cfg      (cfg_reg),
        .coord    (y_reg),
        .cell_idx (row),
        .frac     (fy)
    );

    // ---- address stage ----
    logic [15:0] base_reg;
    logic [8:0]  fx_adr_reg, fx_rd_reg;
    logic [8:0]  fy_adr_reg, fy_rd_reg, fy_lo1_reg, fy_lo_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            base_reg   <= 16'({8'd0, row} * {8'd0, cfg_reg.side}) + {8'd0, col};
            fx_adr_reg <= fx;
            fx_rd_reg  <= fx_adr_reg;
            fy_adr_reg <= fy;
            fy_rd_reg  <= fy_adr_reg;
            fy_lo1_reg <= fy_rd_reg;
            fy_lo_reg  <= fy_lo1_reg;
        end
    end

    logic [16:0] a00, a10, a01, a11;
    logic [3:0]  oob_reg;

    assign a00 = {1'b0, base_reg};
    assign a10 = {1'b0, base_reg} + 17'd1;
    assign a01 = {1'b0, base_reg} + {9'd0, cfg_reg.side};
    assign a11 = {1'b0, base_reg} + {9'd0, cfg_reg.side} + 17'd1;

    // corners past the store read as zero
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            oob_reg <= {a11 >= 17'(STORE_DEPTH), a01 >= 17'(STORE_DEPTH),
                        a10 >= 17'(STORE_DEPTH), a00 >= 17'(STORE_DEPTH)};
        end
    end

    // writes happen at the same stage as reads, so request order holds
    logic              item_we;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [31:0]       ram_wdata;

    assign item_we   = adv && v_reg[S_ADR] && (side_pipe[S_ADR].op == OP_WRITE);
    assign ram_we    = !clr_done || item_we;
    assign ram_waddr = clr_done ? side_pipe[S_ADR].cell_index : clr_reg[ADDR_W-1:0];
    assign ram_wdata = clr_done ? side_pipe[S_ADR].height : 32'd0;

    logic [31:0] rd00, rd10, rd01, rd11;

    gbs_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_ram_lo (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (adv),
        .raddr_a (a00[ADDR_W-1:0]),
        .raddr_b (a10[ADDR_W-1:0]),
        .rdata_a (rd00),
        .rdata_b (rd10)
    );

    gbs_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_ram_hi (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (adv),
        .raddr_a (a01[ADDR_W-1:0]),
        .raddr_b (a11[ADDR_W-1:0]),
        .rdata_a (rd01),
        .rdata_b (rd11)
    );

    logic [31:0] c00, c10, c01, c11;

    assign c00 = oob_reg[0] ? 32'd0 : rd00;
    assign c10 = oob_reg[1] ? 32'd0 : rd10;
    assign c01 = oob_reg[2] ? 32'd0 : rd01;
    assign c11 = oob_reg[3] ? 32'd0 : rd11;

    // ---- interpolation ----
    logic [31:0] lo, hi, hy;

    gbs_lerp u_lerp_lo (.clk(clk), .adv(adv), .a(c00), .b(c10), .t(fx_rd_reg), .q(lo));
    gbs_lerp u_lerp_hi (.clk(clk), .adv(adv), .a(c01), .b(c11), .t(fx_rd_reg), .q(hi));
    gbs_lerp u_lerp_y  (.clk(clk), .adv(adv), .a(lo),  .b(hi),  .t(fy_lo_reg), .q(hy));

    // ---- output register ----
    logic [31:0] out_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= ((side_pipe[S_Y].op == OP_QUERY) && !side_pipe[S_Y].degen)
                       ? hy : 32'd0;
        end
    end

    assign m_tvalid = v_reg[S_OUT];
    assign m_tdata  = out_reg;

    // ---- checks ----
    a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_done |-> (v_reg == '0) && !s_tready)
        else $error("request in flight during store clear");

    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (side_pipe[S_OUT].op == OP_WRITE) |-> m_tdata == 32'd0)
        else $error("write request gave nonzero result");

    a_row_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[S_LOC] && !side_pipe[S_LOC].degen |-> row <= (cfg_reg.side - 8'd2))
        else $error("row beyond clamped grid");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg))
        else $error("pipeline moved during stall");

endmodule

// ----- sv/gbs_ram.sv -----
// Generic RAM: one write port, two registered read ports.
module gbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ----- sv/gbs_locate.sv -----
// One axis: world coordinate to clamped cell and Q.8 fraction, restoring divider.
module gbs_locate import gbs_pkg::*; (
    input  logic        clk,
    input  logic        adv,
    input  cfg_t        cfg,
    input  logic [31:0] coord,
    output logic [7:0]  cell_idx,
    output logic [8:0]  frac
);

    logic signed [33:0] num;
    logic               neg;
    logic               high;

    logic [REM_W-1:0]     rem_reg  [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] quo_reg  [DIV_STEPS+1];
    logic                 neg_reg  [DIV_STEPS+1];
    logic                 high_reg [DIV_STEPS+1];

    logic [7:0] cell_reg;
    logic [8:0] frac_reg;

    // num = 2*x + cell_size*(side-1); position in cells is num / (2*cell_size)
    assign num  = $signed({coord[31], coord, 1'b0}) + $signed({2'b00, cfg.offset});
    assign neg  = num[33];
    assign high = !neg && (num[32:0] >= cfg.limit);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= (neg || high) ? '0 : {num[32:0], 8'd0};
            quo_reg[0]  <= '0;
            neg_reg[0]  <= neg;
            high_reg[0] <= high;
        end
    end

    // one quotient bit per stage, MSB first
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        logic [REM_W-1:0] dsh;
        logic             ge;
        assign dsh = {{(REM_W-25){1'b0}}, cfg.dvsr} << (DIV_STEPS - 1 - i);
        assign ge  = rem_reg[i] >= dsh;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i+1]  <= ge ? (rem_reg[i] - dsh) : rem_reg[i];
                quo_reg[i+1]  <= {quo_reg[i][DIV_STEPS-2:0], ge};
                neg_reg[i+1]  <= neg_reg[i];
                high_reg[i+1] <= high_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            priority if (neg_reg[DIV_STEPS])
            begin
                cell_reg <= '0;
                frac_reg <= '0;
            end
            else if (high_reg[DIV_STEPS])
            begin
                cell_reg <= cfg.side - 8'd2;
                frac_reg <= 9'd256;
            end
            else
            begin
                cell_reg <= quo_reg[DIV_STEPS][15:8];
                frac_reg <= {1'b0, quo_reg[DIV_STEPS][7:0]};
            end
        end
    end

    assign cell_idx = cell_reg;
    assign frac     = frac_reg;

endmodule

// ----- sv/gbs_lerp.sv -----
// Two-stage linear interpolation a + floor((b - a) * t / 256).
module gbs_lerp import gbs_pkg::*; (
    input  logic        clk,
    input  logic        adv,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [8:0]  t,
    output logic [31:0] q
);

    logic signed [32:0] diff;
    logic signed [42:0] prod_next;
    logic signed [42:0] prod_reg;
    logic signed [31:0] a_reg;
    logic signed [42:0] sum;
    logic [31:0]        q_reg;

    assign diff      = $signed({a[31], a}) - $signed({b[31], b});
    assign prod_next = (-43'(diff)) * $signed({1'b0, t});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            a_reg    <= $signed(a);
        end
    end

    // arithmetic shift gives the floor
    assign sum = 43'(a_reg) + (prod_reg >>> 8);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg <= sum[31:0];
        end
    end

    assign q = q_reg;

endmodule
